>>> sv/text_line_number_and_escape_filter_top_macros.svh
// Assertion macros shared by the filter's RTL
`ifndef TEXT_LINE_NUMBER_AND_ESCAPE_FILTER_TOP_MACROS_SVH
`define TEXT_LINE_NUMBER_AND_ESCAPE_FILTER_TOP_MACROS_SVH

// Check that a condition holds in the same cycle as its trigger
`define TLEF_ASSERT_SAME(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error(msg);

// Check that a condition holds in the cycle after its trigger
`define TLEF_ASSERT_NEXT(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

>>> sv/tlef_pkg.sv
// Shared types and constants of the text line-number and escape filter
`timescale 1ns / 1ps
`default_nettype none
package tlef_pkg;

	localparam int NUMBER_DIGITS_DEF = 6;
	localparam int QUEUE_DEPTH_DEF   = 2;

	localparam logic [7:0] CH_TAB      = 8'h09;
	localparam logic [7:0] CH_NL       = 8'h0A;
	localparam logic [7:0] CH_CARET    = 8'h5E;
	localparam logic [7:0] CH_I        = 8'h49;
	localparam logic [7:0] CH_DOLLAR   = 8'h24;
	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] CH_ZERO     = 8'h30;
	localparam logic [7:0] CTRL_MAX    = 8'd31;
	localparam logic [7:0] CTRL_OFFSET = 8'd64;
	localparam logic [1:0] RUN_MAX     = 2'd3;
	localparam logic [3:0] BCD_NINE    = 4'd9;

	localparam int CFG_INDEX_W = 3;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_NUMBER_NONBLANK  = 3'd0,
		CFG_NUMBER_ALL       = 3'd1,
		CFG_SQUEEZE_BLANK    = 3'd2,
		CFG_SHOW_TABS        = 3'd3,
		CFG_SHOW_NONPRINTING = 3'd4,
		CFG_SHOW_ENDS        = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic number_nonblank;
		logic number_all;
		logic squeeze_blank;
		logic show_tabs;
		logic show_nonprinting;
		logic show_ends;
	} cfg_t;

	// Rendering job for one accepted byte; the line number travels beside it
	typedef struct packed {
		logic       num_en;
		logic       two;
		logic [7:0] b0;
		logic [7:0] b1;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage
`default_nettype wire

>>> sv/tlef_front.sv
// Front end: accepts bytes, tracks line state and builds rendering jobs
`timescale 1ns / 1ps
`default_nettype none
module tlef_front #(
	parameter int NUMBER_DIGITS = tlef_pkg::NUMBER_DIGITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire tlef_pkg::cfg_t               cfg,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [7:0]                   text_byte,
	input  wire logic                         file_start,
	input  wire tlef_pkg::q_stat_t            q_stat,
	output logic                              push,
	output tlef_pkg::job_t                    push_job,
	output logic [4*NUMBER_DIGITS-1:0]        push_bcd
);
	import tlef_pkg::*;

	localparam int BW = 4 * NUMBER_DIGITS;

	logic [BW-1:0] bcd_q;
	logic          at_line_start_q;
	logic [1:0]    run_q;

	logic          als;
	logic [1:0]    run_cur;
	logic [1:0]    run_nxt;
	logic          is_nl;
	logic          tab_shown;
	logic          ctrl_shown;
	logic          squeezed;
	logic          accept;
	logic          all_nines;
	logic          carry;
	logic [3:0]    dig;
	logic [BW-1:0] bcd_inc;

	// Classify the incoming byte against the line state
	always_comb begin
		als       = file_start | at_line_start_q;
		run_cur   = file_start ? 2'd0 : run_q;
		is_nl     = (text_byte == CH_NL);
		tab_shown = cfg.show_tabs && (text_byte == CH_TAB);
		ctrl_shown = cfg.show_nonprinting && (text_byte inside {[8'd1:CTRL_MAX]})
			&& (text_byte != CH_TAB) && !is_nl;
		if (!is_nl)
			run_nxt = 2'd0;
		else if (run_cur == RUN_MAX)
			run_nxt = RUN_MAX;
		else
			run_nxt = run_cur + 2'd1;
		squeezed = is_nl && cfg.squeeze_blank && (run_nxt == RUN_MAX);
	end

	// Saturating BCD increment, one digit carry per step
	always_comb begin
		all_nines = 1'b1;
		carry     = 1'b1;
		bcd_inc   = bcd_q;
		for (int i = 0; i < NUMBER_DIGITS; i++) begin
			dig = bcd_q[4*i +: 4];
			if (dig != BCD_NINE)
				all_nines = 1'b0;
			if (carry) begin
				if (dig >= BCD_NINE) begin
					bcd_inc[4*i +: 4] = 4'd0;
				end else begin
					bcd_inc[4*i +: 4] = dig + 4'd1;
					carry = 1'b0;
				end
			end
		end
		if (all_nines)
			bcd_inc = bcd_q;
	end

	// Build the job for the back end
	always_comb begin
		push_job.num_en = als && (cfg.number_nonblank ? !is_nl : cfg.number_all);
		if (tab_shown) begin
			push_job.two = 1'b1;
			push_job.b0  = CH_CARET;
			push_job.b1  = CH_I;
		end else if (ctrl_shown) begin
			push_job.two = 1'b1;
			push_job.b0  = CH_CARET;
			push_job.b1  = text_byte + CTRL_OFFSET;
		end else if (is_nl && cfg.show_ends) begin
			push_job.two = 1'b1;
			push_job.b0  = CH_DOLLAR;
			push_job.b1  = text_byte;
		end else begin
			push_job.two = 1'b0;
			push_job.b0  = text_byte;
			push_job.b1  = text_byte;
		end
		push_bcd = push_job.num_en ? bcd_inc : bcd_q;
	end

	assign in_ready = !q_stat.full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && !squeezed;

	// Advance line state on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcd_q           <= '0;
			at_line_start_q <= 1'b1;
			run_q           <= 2'd0;
		end else if (accept) begin
			run_q <= run_nxt;
			if (squeezed) begin
				at_line_start_q <= als;
			end else begin
				at_line_start_q <= is_nl;
				if (push_job.num_en)
					bcd_q <= bcd_inc;
			end
		end
	end

endmodule
`default_nettype wire

>>> sv/tlef_queue.sv
// Short job queue between front and back ends
`timescale 1ns / 1ps
`default_nettype none
module tlef_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = tlef_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire logic [WIDTH-1:0]  push_data,
	input  wire logic              pop,
	output logic [WIDTH-1:0]       head_data,
	output tlef_pkg::q_stat_t      q_stat
);
	import tlef_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign q_stat.full  = (count_q == CNT_FULL);
	assign q_stat.empty = (count_q == '0);
	assign do_push      = push && !q_stat.full;
	assign do_pop       = pop && !q_stat.empty;
	assign head_data    = mem_q[rd_ptr_q];

	// Hold entries
	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_data;
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PW'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PW'(1);
			if (do_push && !do_pop)
				count_q <= count_q + CW'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - CW'(1);
		end
	end

endmodule
`default_nettype wire

>>> sv/tlef_back.sv
// Back end: expands one job into its output bytes, one per cycle while out_ready is high
`timescale 1ns / 1ps
`default_nettype none
module tlef_back #(
	parameter int NUMBER_DIGITS = tlef_pkg::NUMBER_DIGITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire tlef_pkg::q_stat_t            q_stat,
	input  wire tlef_pkg::job_t               head_job,
	input  wire logic [4*NUMBER_DIGITS-1:0]   head_bcd,
	output logic                              pop,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [7:0]                        out_char,
	output logic                              last_of_run
);
	import tlef_pkg::*;

	localparam int BW = 4 * NUMBER_DIGITS;
	localparam int PW = $clog2(NUMBER_DIGITS + 3);
	localparam logic [PW-1:0] POS_LAST_DIG = PW'(NUMBER_DIGITS - 1);
	localparam logic [PW-1:0] POS_TAB      = PW'(NUMBER_DIGITS);
	localparam logic [PW-1:0] POS_B0       = PW'(NUMBER_DIGITS + 1);
	localparam logic [PW-1:0] POS_B1       = PW'(NUMBER_DIGITS + 2);

	job_t          cur_q;
	logic          cur_valid_q;
	logic [BW-1:0] num_q;
	logic          leading_q;
	logic [PW-1:0] pos_q;
	logic          out_valid_q;
	logic [7:0]    out_char_q;
	logic          last_q;

	logic [3:0]    top_dig;
	logic [7:0]    ch;
	logic          ch_last;
	logic          adv;

	// Select the byte at the current position
	always_comb begin
		top_dig = num_q[BW-1 -: 4];
		ch_last = ((pos_q == POS_B0) && !cur_q.two) || (pos_q == POS_B1);
		if (pos_q < POS_TAB)
			ch = (leading_q && (top_dig == 4'd0) && (pos_q != POS_LAST_DIG))
				? CH_SPACE : (CH_ZERO + {4'd0, top_dig});
		else if (pos_q == POS_TAB)
			ch = CH_TAB;
		else if (pos_q == POS_B0)
			ch = cur_q.b0;
		else
			ch = cur_q.b1;
	end

	assign adv = cur_valid_q && (!out_valid_q || out_ready);
	assign pop = !q_stat.empty && (!cur_valid_q || (adv && ch_last));

	// Step through the current job and load the next one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			pos_q       <= '0;
			leading_q   <= 1'b1;
		end else begin
			if (pop) begin
				cur_valid_q <= 1'b1;
				pos_q       <= head_job.num_en ? '0 : POS_B0;
				leading_q   <= 1'b1;
			end else if (adv) begin
				if (ch_last) begin
					cur_valid_q <= 1'b0;
				end else begin
					pos_q <= pos_q + PW'(1);
					if (pos_q < POS_TAB)
						leading_q <= leading_q && (top_dig == 4'd0);
				end
			end
		end
	end

	// Job payload and digit shifter
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head_job;
			num_q <= head_bcd;
		end else if (adv && (pos_q < POS_TAB)) begin
			num_q <= num_q << 4;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_char_q <= ch;
			last_q     <= ch_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_char    = out_char_q;
	assign last_of_run = last_q;

endmodule
`default_nettype wire

>>> sv/text_line_number_and_escape_filter_top.sv
// Top level of the text line-number and escape filter
//
//  channel | signals                                      | role
//  --------+----------------------------------------------+-----------------------------
//  in      | in_valid, in_ready, text_byte, file_start    | one text byte per transfer
//  out     | out_valid, out_ready, out_char, last_of_run  | one rendered byte per transfer
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data    | mode bit write, always ready
//
// The back end emits one byte per cycle while out_ready is high; a byte yields one output
// byte as plain text and up to NUMBER_DIGITS + 3 as a numbered escaped byte.
// A job queue of QUEUE_DEPTH entries lets input transfers continue while a long
// expansion drains; plain text flows at one byte per cycle while out_ready is high.
// Reset clears the line number, line state, queue and output valid flag at once; there is
// no clearing pass. Squeezed newlines are accepted and produce no output.
`timescale 1ns / 1ps
`default_nettype none
module text_line_number_and_escape_filter_top #(
	parameter int NUMBER_DIGITS = tlef_pkg::NUMBER_DIGITS_DEF,
	parameter int QUEUE_DEPTH   = tlef_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [7:0]                       text_byte,
	input  wire logic                             file_start,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [7:0]                            out_char,
	output logic                                  last_of_run,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [tlef_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic                             cfg_data
);
	import tlef_pkg::*;
	`include "text_line_number_and_escape_filter_top_macros.svh"

	localparam int BW = 4 * NUMBER_DIGITS;
	localparam int JW = $bits(job_t);
	localparam int QW = JW + BW;

	cfg_t          cfg_q;
	q_stat_t       q_stat;
	logic          push;
	job_t          push_job;
	logic [BW-1:0] push_bcd;
	logic          pop;
	logic [QW-1:0] head_data;
	job_t          head_job;
	logic [BW-1:0] head_bcd;

	// Mode registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_NUMBER_NONBLANK:  cfg_q.number_nonblank  <= cfg_data;
				CFG_NUMBER_ALL:       cfg_q.number_all       <= cfg_data;
				CFG_SQUEEZE_BLANK:    cfg_q.squeeze_blank    <= cfg_data;
				CFG_SHOW_TABS:        cfg_q.show_tabs        <= cfg_data;
				CFG_SHOW_NONPRINTING: cfg_q.show_nonprinting <= cfg_data;
				CFG_SHOW_ENDS:        cfg_q.show_ends        <= cfg_data;
				default: ;
			endcase
		end
	end

	tlef_front #(
		.NUMBER_DIGITS(NUMBER_DIGITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.text_byte  (text_byte),
		.file_start (file_start),
		.q_stat     (q_stat),
		.push       (push),
		.push_job   (push_job),
		.push_bcd   (push_bcd)
	);

	tlef_queue #(
		.WIDTH(QW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_bcd, push_job}),
		.pop       (pop),
		.head_data (head_data),
		.q_stat    (q_stat)
	);

	assign head_job = head_data[JW-1:0];
	assign head_bcd = head_data[QW-1:JW];

	tlef_back #(
		.NUMBER_DIGITS(NUMBER_DIGITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_stat      (q_stat),
		.head_job    (head_job),
		.head_bcd    (head_bcd),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_char    (out_char),
		.last_of_run (last_of_run)
	);

	// A queue can never report full and empty together
	`TLEF_ASSERT_SAME(a_queue_stat, q_stat.full, !q_stat.empty, "queue full and empty")
	// The back end pops only what the queue holds
	`TLEF_ASSERT_SAME(a_pop_nonempty, pop, !q_stat.empty, "pop from empty queue")
	// A run continues without a gap once its first byte is taken
	`TLEF_ASSERT_NEXT(a_run_gapless, out_valid && out_ready && !last_of_run, out_valid,
		"gap inside an output run")

endmodule
`default_nettype wire
